// ----- sv/rvialj_pkg.sv -----
// ============================================================================
// rvialj_pkg: shared definitions for the RV32 I-type execute unit
// Opcodes, minor operation codes, status codes, configuration register
// indexes and reset values.
// ============================================================================
package rvialj_pkg;

    // Default storage behind each segment window, in bytes (power of two)
    localparam int unsigned SEGMENT_BYTES_DEF = 4096;

    // Byte lanes of the segment memories; one lane per byte of a word
    localparam int unsigned LANES  = 4;
    localparam int unsigned LANE_W = 2;

    // Major opcodes
    localparam logic [6:0] OP_ARITH = 7'b0010011;
    localparam logic [6:0] OP_LOAD  = 7'b0000011;
    localparam logic [6:0] OP_JALR  = 7'b1100111;

    // Minor operation codes
    localparam logic [2:0] F3_ADDI = 3'b000;
    localparam logic [2:0] F3_ORI  = 3'b110;
    localparam logic [2:0] F3_ANDI = 3'b111;
    localparam logic [2:0] F3_LB   = 3'b000;
    localparam logic [2:0] F3_LH   = 3'b001;
    localparam logic [2:0] F3_LW   = 3'b010;
    localparam logic [2:0] F3_LWX  = 3'b011;
    localparam logic [2:0] F3_JALR = 3'b000;

    // Item kinds
    localparam logic FUNC_EXEC  = 1'b0;
    localparam logic FUNC_STORE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_OOW     = 2'd1;
    localparam logic [1:0] ST_UNSUP   = 2'd2;
    localparam logic [1:0] ST_STORED  = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_END    = 2'd3;

    // Configuration reset values
    localparam logic [31:0] RST_STACK_START = 32'h7FFF_F000;
    localparam logic [31:0] RST_STACK_END   = 32'h8000_0000;
    localparam logic [31:0] RST_DATA_START  = 32'h1000_0000;
    localparam logic [31:0] RST_DATA_END    = 32'h1000_1000;

endpackage

// ----- sv/rvialj_ram.sv -----
// ============================================================================
// rvialj_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds while the
// read enable is low.
// ============================================================================
module rvialj_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/rv32_itype_alu_load_jalr_unit_top.sv -----
// ============================================================================
// rv32_itype_alu_load_jalr_unit_top: RV32 I-type execute unit
// Executes addi/ori/andi, lb/lh/lw (funct3 3 also loads a word) and jalr against a 32-entry register file
// and two windowed byte memories (stack and data), and stores single bytes.
// ============================================================================
// Pipeline: an item passes the stage 1, stage 2 and output registers in turn.
// Throughput: one item per cycle when not stalled; set by the combinational
//   regfile read (with forwarding from stage 2), one access per cycle per lane.
// Reset: register file and window registers reset at once; both byte
//   memories are then zeroed by a clearing pass over every row of each lane,
//   during which o_in_stall stays high (configuration writes still land).
// ============================================================================
module rv32_itype_alu_load_jalr_unit_top #(
    // Bytes behind each window; must be a power of two, at least 16
    parameter int unsigned SEGMENT_BYTES = rvialj_pkg::SEGMENT_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [rvialj_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                        i_cfg_data,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_func,
    input  logic [6:0]                         i_opcode,
    input  logic [2:0]                         i_funct3,
    input  logic [4:0]                         i_dest_index,
    input  logic [4:0]                         i_src_index,
    input  logic signed [11:0]                 i_immediate,
    input  logic [31:0]                        i_pc,
    input  logic [31:0]                        i_store_addr,
    input  logic [7:0]                         i_store_byte,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [1:0]                         o_status,
    output logic                               o_reg_written,
    output logic [4:0]                         o_written_index,
    output logic signed [31:0]                 o_written_value,
    output logic [31:0]                        o_next_pc
);

    import rvialj_pkg::*;

    localparam int unsigned SEG_AW     = $clog2(SEGMENT_BYTES);
    localparam int unsigned BANK_DEPTH = SEGMENT_BYTES / LANES;
    localparam int unsigned ROW_W      = SEG_AW - LANE_W;

    // ------------------------------------------------------------------
    // Window registers
    // ------------------------------------------------------------------
    logic [31:0] r_stack_start, r_stack_end, r_data_start, r_data_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_start <= RST_STACK_START;
            r_stack_end   <= RST_STACK_END;
            r_data_start  <= RST_DATA_START;
            r_data_end    <= RST_DATA_END;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STACK_START: r_stack_start <= i_cfg_data;
                CFG_STACK_END:   r_stack_end   <= i_cfg_data;
                CFG_DATA_START:  r_data_start  <= i_cfg_data;
                CFG_DATA_END:    r_data_end    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together whenever the output
    // register is empty or its transfer completes this cycle.
    // ------------------------------------------------------------------
    logic r_clr;
    logic [ROW_W-1:0] r_clr_row;
    logic r_v1, r_v2, r_ov;
    logic en, in_acc;

    assign en         = !r_ov || !i_out_stall;
    assign o_in_stall = !en || r_clr;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Clearing pass over all byte lanes after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_row <= '0;
        end else if (r_clr) begin
            r_clr_row <= r_clr_row + ROW_W'(1);
            if (r_clr_row == ROW_W'(BANK_DEPTH - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic        r_s1_func;
    logic [6:0]  r_s1_opcode;
    logic [2:0]  r_s1_funct3;
    logic [4:0]  r_s1_rd, r_s1_rs1;
    logic [11:0] r_s1_imm;
    logic [31:0] r_s1_pc, r_s1_saddr;
    logic [7:0]  r_s1_sbyte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_func   <= i_func;
            r_s1_opcode <= i_opcode;
            r_s1_funct3 <= i_funct3;
            r_s1_rd     <= i_dest_index;
            r_s1_rs1    <= i_src_index;
            r_s1_imm    <= i_immediate;
            r_s1_pc     <= i_pc;
            r_s1_saddr  <= i_store_addr;
            r_s1_sbyte  <= i_store_byte;
        end
    end

    // ------------------------------------------------------------------
    // Register file; written when stage 2 moves to the output register
    // ------------------------------------------------------------------
    logic [31:0] r_rf [32];
    logic        r_s2_write;
    logic [4:0]  r_s2_rd;
    logic [31:0] s2_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) begin
                r_rf[i] <= '0;
            end
        end else if (en && r_v2 && r_s2_write) begin
            r_rf[r_s2_rd] <= s2_value;
        end
    end

    // Forward the stage 2 result when it targets our source register
    logic [31:0] src_a, imm32, sum, addr, pc_plus4;

    always_comb begin
        if (r_v2 && r_s2_write && (r_s2_rd == r_s1_rs1)) begin
            src_a = s2_value;
        end else begin
            src_a = r_rf[r_s1_rs1];
        end
    end

    assign imm32    = {{20{r_s1_imm[11]}}, r_s1_imm};
    assign sum      = src_a + imm32;
    assign pc_plus4 = r_s1_pc + 32'd4;
    assign addr     = (r_s1_func == FUNC_STORE) ? r_s1_saddr : sum;

    // Window match; stack window has priority
    logic              in_stack, in_data, hit;
    logic [SEG_AW-1:0] stack_off, data_off, off;

    assign in_stack  = (addr >= r_stack_start) && (addr < r_stack_end);
    assign in_data   = (addr >= r_data_start) && (addr < r_data_end);
    assign hit       = in_stack || in_data;
    assign stack_off = addr[SEG_AW-1:0] - r_stack_start[SEG_AW-1:0];
    assign data_off  = addr[SEG_AW-1:0] - r_data_start[SEG_AW-1:0];
    assign off       = in_stack ? stack_off : data_off;

    // Decode and execute
    logic [1:0]  s1_status;
    logic        s1_write, s1_load, s1_store, s1_wr_en;
    logic [31:0] s1_value, s1_next_pc;

    always_comb begin
        s1_status  = ST_DONE;
        s1_write   = 1'b0;
        s1_load    = 1'b0;
        s1_store   = 1'b0;
        s1_value   = '0;
        s1_next_pc = pc_plus4;
        if (r_s1_func == FUNC_STORE) begin
            s1_next_pc = '0;
            if (hit) begin
                s1_status = ST_STORED;
                s1_store  = 1'b1;
            end else begin
                s1_status = ST_OOW;
            end
        end else begin
            case (r_s1_opcode)
                OP_ARITH: begin
                    if (r_s1_funct3 inside {F3_ADDI, F3_ORI, F3_ANDI}) begin
                        s1_write = 1'b1;
                        case (r_s1_funct3)
                            F3_ORI:  s1_value = src_a | imm32;
                            F3_ANDI: s1_value = src_a & imm32;
                            default: s1_value = sum;
                        endcase
                    end else begin
                        s1_status = ST_UNSUP;
                    end
                end
                OP_LOAD: begin
                    if (r_s1_funct3 inside {F3_LB, F3_LH, F3_LW, F3_LWX}) begin
                        if (hit) begin
                            s1_write = 1'b1;
                            s1_load  = 1'b1;
                        end else begin
                            s1_status = ST_OOW;
                        end
                    end else begin
                        s1_status = ST_UNSUP;
                    end
                end
                OP_JALR: begin
                    if (r_s1_funct3 == F3_JALR) begin
                        s1_write   = 1'b1;
                        s1_value   = pc_plus4;
                        s1_next_pc = {sum[31:1], 1'b0};
                    end else begin
                        s1_status = ST_UNSUP;
                    end
                end
                default: s1_status = ST_UNSUP;
            endcase
        end
    end

    // Writes to x0 are dropped
    assign s1_wr_en = s1_write && (r_s1_rd != 5'd0);

    // ------------------------------------------------------------------
    // Byte memories: four lanes per segment, a word spread across lanes
    // so that four consecutive bytes (wrapping) read in the same cycle.
    // ------------------------------------------------------------------
    logic             store_go;
    logic [7:0]       stack_q [LANES];
    logic [7:0]       data_q  [LANES];
    logic [ROW_W-1:0] rd_row  [LANES];
    logic [ROW_W-1:0] wr_row;
    logic [7:0]       wr_byte;

    assign store_go = en && r_v1 && s1_store;
    assign wr_row   = r_clr ? r_clr_row : off[SEG_AW-1:LANE_W];
    assign wr_byte  = r_clr ? 8'd0 : r_s1_sbyte;

    for (genvar b = 0; b < LANES; b++) begin : g_lane
        logic lane_sel, we_stack, we_data;

        assign lane_sel = (off[LANE_W-1:0] == LANE_W'(b));
        assign we_stack = r_clr || (store_go && in_stack && lane_sel);
        assign we_data  = r_clr || (store_go && !in_stack && lane_sel);
        // lanes below the starting lane hold bytes of the next row
        assign rd_row[b] = off[SEG_AW-1:LANE_W]
                         + ROW_W'(LANE_W'(b) < off[LANE_W-1:0]);

        rvialj_ram #(
            .WIDTH (8),
            .DEPTH (BANK_DEPTH)
        ) u_stack_ram (
            .i_clk   (i_clk),
            .i_we    (we_stack),
            .i_waddr (wr_row),
            .i_wdata (wr_byte),
            .i_re    (en),
            .i_raddr (rd_row[b]),
            .o_rdata (stack_q[b])
        );

        rvialj_ram #(
            .WIDTH (8),
            .DEPTH (BANK_DEPTH)
        ) u_data_ram (
            .i_clk   (i_clk),
            .i_we    (we_data),
            .i_waddr (wr_row),
            .i_wdata (wr_byte),
            .i_re    (en),
            .i_raddr (rd_row[b]),
            .o_rdata (data_q[b])
        );
    end

    // ------------------------------------------------------------------
    // Stage 2: decoded result, load data arriving from the lanes
    // ------------------------------------------------------------------
    logic [1:0]        r_s2_status;
    logic              r_s2_load, r_s2_stack;
    logic [2:0]        r_s2_funct3;
    logic [LANE_W-1:0] r_s2_rot;
    logic [31:0]       r_s2_value, r_s2_next_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_status  <= s1_status;
            r_s2_write   <= s1_wr_en;
            r_s2_rd      <= s1_wr_en ? r_s1_rd : 5'd0;
            r_s2_load    <= s1_wr_en && s1_load;
            r_s2_value   <= (s1_wr_en && !s1_load) ? s1_value : 32'd0;
            r_s2_next_pc <= s1_next_pc;
            r_s2_funct3  <= r_s1_funct3;
            r_s2_rot     <= off[LANE_W-1:0];
            r_s2_stack   <= in_stack;
        end
    end

    // Rotate lanes back into byte order and sign-extend
    logic [7:0]  ld_b [LANES];
    logic [31:0] ld_value;

    always_comb begin
        logic [LANE_W-1:0] idx;
        for (int k = 0; k < LANES; k++) begin
            idx     = r_s2_rot + LANE_W'(k);
            ld_b[k] = r_s2_stack ? stack_q[idx] : data_q[idx];
        end
        case (r_s2_funct3)
            F3_LB:   ld_value = {{24{ld_b[0][7]}}, ld_b[0]};
            F3_LH:   ld_value = {{16{ld_b[1][7]}}, ld_b[1], ld_b[0]};
            default: ld_value = {ld_b[3], ld_b[2], ld_b[1], ld_b[0]};
        endcase
    end

    assign s2_value = r_s2_load ? ld_value : r_s2_value;

    // ------------------------------------------------------------------
    // Output register: hold while stalled, advance on transfer
    // ------------------------------------------------------------------
    logic [1:0]  r_out_status;
    logic        r_out_written;
    logic [4:0]  r_out_index;
    logic [31:0] r_out_value, r_out_next_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_status  <= r_s2_status;
            r_out_written <= r_s2_write;
            r_out_index   <= r_s2_rd;
            r_out_value   <= s2_value;
            r_out_next_pc <= r_s2_next_pc;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_status        = r_out_status;
    assign o_reg_written   = r_out_written;
    assign o_written_index = r_out_index;
    assign o_written_value = r_out_value;
    assign o_next_pc       = r_out_next_pc;

endmodule
